@@ rtl/csrm_pkg.sv @@
// Shared types and constants for the compressed-row sparse matrix engine.
package csrm_pkg;

    typedef enum logic [1:0] {
        MODE_SET  = 2'd0,
        MODE_GET  = 2'd1,
        MODE_LOAD = 2'd2,
        MODE_PROD = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    localparam int unsigned REG_ROW_COUNT = 0;
    localparam int unsigned REG_COL_COUNT = 1;
    localparam int unsigned CFG_IDX_BITS  = 1;
    localparam int unsigned CFG_BITS      = 9;
    localparam int unsigned COUNT_BITS    = 13;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RS_LO,
        S_RS_HI,
        S_BS_RD,
        S_BS_CMP,
        S_SH_RD,
        S_SH_WR,
        S_INS,
        S_RS_INC,
        S_PR_RD,
        S_PR_VEC,
        S_PR_MUL,
        S_PR_ACC,
        S_CLR,
        S_DONE
    } state_t;

endpackage

@@ rtl/csrm_ram.sv @@
// Generic RAM with one write port, one read port and registered read data.
module csrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/csrm_mac.sv @@
// Shared multiply-accumulate unit: one registered product, then an add into the sum.
module csrm_mac #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         clr,
    input  logic                         mul_en,
    input  logic                         acc_en,
    input  logic signed [VALUE_BITS-1:0] a,
    input  logic signed [VALUE_BITS-1:0] b,
    output logic [63:0]                  sum
);
    logic signed [2*VALUE_BITS-1:0] prod_reg;
    logic [63:0]                    sum_reg;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= a * b;
        end
        if (clr) begin
            sum_reg <= '0;
        end else if (acc_en) begin
            sum_reg <= sum_reg + 64'(prod_reg);
        end
    end

    assign sum = sum_reg;
endmodule

@@ rtl/csr_sparse_matrix_engine.sv @@
// Top level of the compressed-row sparse matrix engine.
//
// Requests arrive on the s_ channel; each gives exactly one response on the m_
// channel. A request is set, get, vector load or row product (s_tuser is the
// mode). Configuration writes (row_count, col_count) use cfg_we/cfg_idx/
// cfg_data, take effect at once and should only be issued while the block is idle.
//
// All work is done by one sequencer over memories that each have one write
// and one read port. A get is a binary search of the row's entries. An insert
// moves each entry above the insertion point up by one, then raises the
// (MAX_ROWS - row) row starts after the row. A row product passes each stored
// entry of the row through the one multiply-accumulate unit.
// s_tready is high only in the idle state, so one request is in flight.
//
// After reset a clearing pass zeroes the MAX_COLS entries of the vector store
// and the MAX_ROWS+1 entries of the row-start table together; no request is
// taken meanwhile. The response is held in its registers until m_tready; the
// block waits there and then returns to idle.
module csr_sparse_matrix_engine #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 256,
    parameter int MAX_ENTRIES = 4096,
    parameter int VALUE_BITS  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,  // row[7:0], col[15:8], value[47:16]
    input  logic [1:0]                    s_tuser,  // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [79:0]                   m_tdata,  // result_value[63:0], stored_count[76:64]
    output logic [1:0]                    m_tuser,  // status
    input  logic                          cfg_we,
    input  logic [csrm_pkg::CFG_IDX_BITS-1:0] cfg_idx,
    input  logic [csrm_pkg::CFG_BITS-1:0] cfg_data
);
    import csrm_pkg::*;

    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int EW  = $clog2(MAX_ENTRIES);
    localparam int NW  = $clog2(MAX_ENTRIES + 1);
    localparam int CLW = (RW > CW) ? RW : CW;

    // Registers and sequencer state.
    state_t state_reg, state_next;
    logic [8:0] rows_reg, cols_reg;
    mode_t mode_reg;
    logic [7:0] row_reg, col_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [NW-1:0] count_reg, count_next;
    logic [NW-1:0] lo_reg, lo_next, hi_reg, hi_next, ptr_reg, ptr_next;
    logic [RW-1:0] rs_ptr_reg, rs_ptr_next;
    logic [CLW:0] clr_reg, clr_next;
    logic [63:0] res_reg, res_next;
    status_t st_reg, st_next;
    logic [7:0] carry_col_reg;
    logic [VALUE_BITS-1:0] carry_val_reg;
    logic carry_ld;
    logic [63:0] out_val;

    // Memory ports.
    logic rs_we; logic [RW-1:0] rs_wa, rs_ra; logic [NW-1:0] rs_wd, rs_rd;
    logic ix_we; logic [EW-1:0] ix_wa, ix_ra; logic [7:0] ix_wd, ix_rd;
    logic vl_we; logic [VALUE_BITS-1:0] vl_wd, vl_rd;
    logic vc_we; logic [CW-1:0] vc_wa, vc_ra; logic [VALUE_BITS-1:0] vc_wd, vc_rd;
    logic mac_clr, mac_mul, mac_acc; logic [63:0] mac_sum;

    csrm_ram #(.WIDTH(NW), .DEPTH(MAX_ROWS + 1)) u_rs (
        .aclk(aclk), .we(rs_we), .waddr(rs_wa), .wdata(rs_wd), .raddr(rs_ra), .rdata(rs_rd));
    csrm_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES)) u_ix (
        .aclk(aclk), .we(ix_we), .waddr(ix_wa), .wdata(ix_wd), .raddr(ix_ra), .rdata(ix_rd));
    csrm_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ENTRIES)) u_vl (
        .aclk(aclk), .we(vl_we), .waddr(ix_wa), .wdata(vl_wd), .raddr(ix_ra), .rdata(vl_rd));
    csrm_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_COLS)) u_vc (
        .aclk(aclk), .we(vc_we), .waddr(vc_wa), .wdata(vc_wd), .raddr(vc_ra), .rdata(vc_rd));
    csrm_mac #(.VALUE_BITS(VALUE_BITS)) u_mac (
        .aclk(aclk), .clr(mac_clr), .mul_en(mac_mul), .acc_en(mac_acc),
        .a(vl_rd), .b(vc_rd), .sum(mac_sum));

    // Input unpacking and range checks.
    logic [7:0] in_row, in_col;
    logic row_ok, col_ok;
    logic [NW-1:0] mid;
    assign in_row = s_tdata[7:0];
    assign in_col = s_tdata[15:8];
    assign row_ok = (32'(in_row) < MAX_ROWS) && ({1'b0, in_row} < rows_reg);
    assign col_ok = (32'(in_col) < MAX_COLS) && ({1'b0, in_col} < cols_reg);
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // A finished row product is presented straight from the accumulator, which
    // holds still until a later set, get or row product in range clears it.
    assign out_val  = (mode_reg == MODE_PROD && st_reg == ST_OK) ? mac_sum : res_reg;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_DONE);
    assign m_tdata  = {3'b000, (COUNT_BITS)'(count_reg), out_val};
    assign m_tuser  = st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            rows_reg  <= 9'd256;
            cols_reg  <= 9'd256;
            count_reg <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
            if (cfg_we && cfg_idx == CFG_IDX_BITS'(REG_ROW_COUNT)) rows_reg <= cfg_data;
            if (cfg_we && cfg_idx == CFG_IDX_BITS'(REG_COL_COUNT)) cols_reg <= cfg_data;
        end
        lo_reg <= lo_next; hi_reg <= hi_next; ptr_reg <= ptr_next;
        rs_ptr_reg <= rs_ptr_next; res_reg <= res_next; st_reg <= st_next;
        if (s_tvalid && s_tready) begin
            mode_reg <= mode_t'(s_tuser);
            row_reg  <= in_row;
            col_reg  <= in_col;
            val_reg  <= s_tdata[16 +: VALUE_BITS];
        end
        if (carry_ld) begin
            carry_col_reg <= ix_rd;
            carry_val_reg <= vl_rd;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next = lo_reg; hi_next = hi_reg; ptr_next = ptr_reg;
        rs_ptr_next = rs_ptr_reg; clr_next = clr_reg;
        res_next = res_reg; st_next = st_reg;
        rs_we = 1'b0; rs_wa = rs_ptr_reg; rs_wd = rs_rd; rs_ra = rs_ptr_reg;
        ix_we = 1'b0; ix_wa = ptr_reg[EW-1:0]; ix_wd = carry_col_reg;
        vl_we = 1'b0; vl_wd = carry_val_reg; ix_ra = ptr_reg[EW-1:0];
        vc_we = 1'b0; vc_wa = col_reg[CW-1:0]; vc_wd = val_reg; vc_ra = ix_rd[CW-1:0];
        mac_clr = 1'b0; mac_mul = 1'b0; mac_acc = 1'b0; carry_ld = 1'b0;
        case (state_reg)
            S_CLR: begin
                // Zero both row-start table and vector store, one entry a cycle.
                if (32'(clr_reg) <= MAX_ROWS) begin
                    rs_we = 1'b1; rs_wa = clr_reg[RW-1:0]; rs_wd = '0;
                end
                if (32'(clr_reg) < MAX_COLS) begin
                    vc_we = 1'b1; vc_wa = clr_reg[CW-1:0]; vc_wd = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) >= MAX_ROWS && 32'(clr_reg) >= MAX_COLS - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                rs_ra = RW'(in_row);
                res_next = '0; st_next = ST_OK;
                if (s_tvalid) begin
                    rs_ptr_next = RW'(in_row) + 1'b1;
                    case (mode_t'(s_tuser))
                        MODE_LOAD: begin
                            if (col_ok) begin
                                vc_we = 1'b1; vc_wa = in_col[CW-1:0];
                                vc_wd = s_tdata[16 +: VALUE_BITS];
                            end else st_next = ST_RANGE;
                            state_next = S_DONE;
                        end
                        MODE_PROD: begin
                            if (row_ok) state_next = S_RS_LO;
                            else begin st_next = ST_RANGE; state_next = S_DONE; end
                        end
                        default: begin
                            if (row_ok && col_ok) state_next = S_RS_LO;
                            else begin st_next = ST_RANGE; state_next = S_DONE; end
                        end
                    endcase
                end
            end
            S_RS_LO: begin
                lo_next = rs_rd;
                rs_ra = rs_ptr_reg;
                mac_clr = 1'b1;
                state_next = S_RS_HI;
            end
            S_RS_HI: begin
                hi_next = (rs_rd > count_reg) ? count_reg : rs_rd;
                if (lo_reg > ((rs_rd > count_reg) ? count_reg : rs_rd))
                    lo_next = (rs_rd > count_reg) ? count_reg : rs_rd;
                if (mode_reg == MODE_PROD) begin
                    ptr_next = lo_reg;
                    state_next = S_PR_RD;
                end else state_next = S_BS_RD;
            end
            S_BS_RD: begin
                if (lo_reg < hi_reg) begin
                    ix_ra = mid[EW-1:0];
                    ptr_next = mid;
                    state_next = S_BS_CMP;
                end else if (mode_reg == MODE_GET) begin
                    state_next = S_DONE;
                end else if (count_reg >= NW'(MAX_ENTRIES)) begin
                    st_next = ST_FULL; state_next = S_DONE;
                end else begin
                    // Shift entries [lo, count) up by one, from the top down.
                    ptr_next = count_reg;
                    state_next = S_SH_RD;
                end
            end
            S_BS_CMP: begin
                if (ix_rd == col_reg) begin
                    if (mode_reg == MODE_GET) begin
                        res_next = 64'(signed'(vl_rd));
                    end else begin
                        vl_we = 1'b1; vl_wd = val_reg;
                    end
                    state_next = S_DONE;
                end else begin
                    if (ix_rd < col_reg) lo_next = ptr_reg + 1'b1;
                    else hi_next = ptr_reg;
                    state_next = S_BS_RD;
                end
            end
            S_SH_RD: begin
                if (ptr_reg == lo_reg) state_next = S_INS;
                else begin
                    ix_ra = EW'(ptr_reg - 1'b1);
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                ix_we = 1'b1; vl_we = 1'b1;
                ix_wd = ix_rd; vl_wd = vl_rd;
                ptr_next = ptr_reg - 1'b1;
                state_next = S_SH_RD;
            end
            S_INS: begin
                ix_we = 1'b1; vl_we = 1'b1;
                ix_wd = col_reg; vl_wd = val_reg;
                count_next = count_reg + 1'b1;
                rs_ra = rs_ptr_reg;
                state_next = S_RS_INC;
            end
            S_RS_INC: begin
                // rs_rd holds row_start[rs_ptr]; raise it and read the next.
                rs_we = 1'b1; rs_wd = rs_rd + 1'b1;
                rs_ra = rs_ptr_reg + 1'b1;
                rs_ptr_next = rs_ptr_reg + 1'b1;
                if (32'(rs_ptr_reg) == MAX_ROWS) state_next = S_DONE;
            end
            S_PR_RD: begin
                if (ptr_reg < hi_reg) state_next = S_PR_VEC;
                else state_next = S_PR_ACC;
            end
            S_PR_VEC: begin
                vc_ra = ix_rd[CW-1:0];
                carry_ld = 1'b1;
                state_next = S_PR_MUL;
            end
            S_PR_MUL: begin
                mac_mul = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                state_next = S_PR_ACC;
            end
            S_PR_ACC: begin
                if (ptr_reg <= hi_reg && ptr_reg != lo_reg) mac_acc = 1'b1;
                lo_next = hi_reg + 1'b1;
                if (ptr_reg < hi_reg) state_next = S_PR_RD;
                else state_next = S_DONE;
            end
            S_DONE: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

@@ rtl/csrm_checker.sv @@
// Port-level checks for the sparse matrix engine, bound to the top level.
module csrm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import csrm_pkg::*;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("request taken while response pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("response changed under stall");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[63:0] == 64'd0)
        else $error("error response carries data");
    a_no_rsvd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != ST_RSVD) else $error("reserved status");
endmodule

bind csr_sparse_matrix_engine csrm_checker u_csrm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser));
